// File: hw/rtl/opbb_pkg.sv
// Shared constants for the page-addressed OLED bitmap blitter.
`default_nettype none

package opbb_pkg;

  // Default size limits of one bitmap
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  // Input item kinds carried in s_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Display controller command bases
  localparam logic [7:0] PAGE_CMD_BASE   = 8'hB0;
  localparam logic [7:0] COL_LO_CMD_BASE = 8'h00;
  localparam logic [7:0] COL_HI_CMD_BASE = 8'h10;
  localparam logic [7:0] NIBBLE_MASK     = 8'h0F;

  // Pixel rows per display page
  localparam int PAGE_ROWS = 8;

endpackage

`default_nettype wire

// File: hw/rtl/oled_page_bitmap_blitter_core.sv
// Page-addressed OLED bitmap blitter: geometry intake, row shift, spill merge, command framing.
`default_nettype none

// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  -----------------------------------------------------
// s_*      in   s_tvalid/s_tready  s_tdata: geometry + pixel byte, s_tuser: item kind
// m_*      out  m_tvalid/m_tready  m_tdata: link byte, m_tuser: is_data/done, m_tlast
//
// Start items, and pixel bytes taken while no bitmap is active, produce no output.
// A pixel byte inside a page row yields one data byte; the first byte of a page row
// is preceded by three page/column command bytes. The final byte of a bitmap with a
// nonzero row offset adds the spill page: three commands plus width_held data bytes,
// read one per cycle while m_tready allows from the single-port spill row store.
// A one-entry job register sits between intake and the output register, so one
// item is taken while a result waits on m_tready. rst (synchronous) clears all
// control state; the spill row store has no reset and is always written before read.

module oled_page_bitmap_blitter_core #(
  parameter int MAX_WIDTH  = opbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = opbb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // bits 7:0 pos_x, 13:8 pos_y, 21:14 bmp_width, 29:22 bmp_height, 37:30 pixel_byte,
  // 39:38 zero
  input  wire logic [39:0] s_tdata,
  // bit 0 command
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // bits 7:0 out_byte
  output logic [7:0]       m_tdata,
  // bit 0 is_data, bit 1 bitmap_done
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  // Derived widths
  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
  localparam int WW        = $clog2(MAX_WIDTH + 1);                      // width count
  localparam int MAX_PAGES = (MAX_HEIGHT + opbb_pkg::PAGE_ROWS - 1) / opbb_pkg::PAGE_ROWS;
  localparam int PTW       = $clog2(MAX_PAGES + 1);                      // page count

  // Emission steps of one job
  localparam logic [2:0] ST_H0 = 3'd0;  // page command
  localparam logic [2:0] ST_H1 = 3'd1;  // column low nibble
  localparam logic [2:0] ST_H2 = 3'd2;  // column high nibble
  localparam logic [2:0] ST_DB = 3'd3;  // merged data byte
  localparam logic [2:0] ST_T0 = 3'd4;  // spill page command
  localparam logic [2:0] ST_T1 = 3'd5;
  localparam logic [2:0] ST_T2 = 3'd6;
  localparam logic [2:0] ST_TB = 3'd7;  // spill page data bytes

  // Input fields
  logic       in_cmd;
  logic [7:0] in_pos_x;
  logic [5:0] in_pos_y;
  logic [7:0] in_width;
  logic [7:0] in_height;
  logic [7:0] in_pixel;

  assign in_cmd    = s_tuser[0];
  assign in_pos_x  = s_tdata[7:0];
  assign in_pos_y  = s_tdata[13:8];
  assign in_width  = s_tdata[21:14];
  assign in_height = s_tdata[29:22];
  assign in_pixel  = s_tdata[37:30];

  // Bitmap geometry and position
  logic [7:0]     origin_col;
  logic [2:0]     first_page;
  logic [2:0]     row_shift;
  logic [WW-1:0]  width_held;
  logic [PTW-1:0] pages_total;
  logic [CW-1:0]  col_count;
  logic [PTW-1:0] page_count;
  logic           active;

  // Pending job: everything the emitter needs for one pixel byte
  logic           job_valid;
  logic [2:0]     job_step;
  logic [7:0]     job_page;
  logic [7:0]     job_byte;    // pixel shifted into place
  logic [7:0]     job_spill;   // bits pushed into the next page
  logic [CW-1:0]  job_col;
  logic           job_merge;   // not the first bitmap page: OR in stored spill
  logic           job_tail;    // spill page follows
  logic           job_fin;     // last byte of the bitmap
  logic [CW-1:0]  tail_col;

  // Spill row store
  logic [7:0] prev_page_row [MAX_WIDTH];

  // Output register
  logic       out_is_data;
  logic       out_done;

  // Intake decode
  logic        s_xfer;
  logic        start_ok;
  logic        pix_take;
  logic [15:0] shifted;
  logic        last_col;
  logic        last_page;
  logic [8:0]  height_round;

  // Emitter control
  logic          out_load;
  logic          step_final;
  logic          tail_end;
  logic [CW-1:0] rd_addr;
  logic [7:0]    hdr_page;

  assign shifted      = {8'h00, in_pixel} << row_shift;
  assign height_round = {1'b0, in_height} + 9'd7;

  assign start_ok = (in_width != 8'd0) && (in_height != 8'd0) &&
                    (in_width <= 8'(MAX_WIDTH)) && (in_height <= 8'(MAX_HEIGHT));

  assign last_col  = ((WW + 1)'(col_count) + (WW + 1)'(1)) >= (WW + 1)'(width_held);
  assign last_page = ((PTW + 1)'(page_count) + (PTW + 1)'(1)) >= (PTW + 1)'(pages_total);

  assign tail_end = ((WW + 1)'(tail_col) + (WW + 1)'(1)) >= (WW + 1)'(width_held);

  // Last result of the job in the emitter
  assign step_final = ((job_step == ST_DB) && !job_tail) || ((job_step == ST_TB) && tail_end);

  assign out_load = job_valid && (!m_tvalid || m_tready);
  assign s_tready = !job_valid || (out_load && step_final);
  assign s_xfer   = s_tvalid && s_tready;
  assign pix_take = s_xfer && (in_cmd == opbb_pkg::CMD_PIXEL) && active;

  assign rd_addr  = (job_step == ST_TB) ? tail_col : job_col;
  assign hdr_page = (job_step == ST_T0) ? (job_page + 8'd1) : job_page;

  // Geometry and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col  <= '0;
      first_page  <= '0;
      row_shift   <= '0;
      width_held  <= '0;
      pages_total <= '0;
      col_count   <= '0;
      page_count  <= '0;
      active      <= 1'b0;
    end else if (s_xfer && (in_cmd == opbb_pkg::CMD_START)) begin
      if (start_ok) begin
        origin_col  <= in_pos_x;
        first_page  <= in_pos_y[5:3];
        row_shift   <= in_pos_y[2:0];
        width_held  <= WW'(in_width);
        pages_total <= PTW'(height_round[8:3]);
        col_count   <= '0;
        page_count  <= '0;
        active      <= 1'b1;
      end else begin
        active <= 1'b0;
      end
    end else if (pix_take) begin
      if (last_col && last_page) begin
        active     <= 1'b0;
        col_count  <= '0;
        page_count <= '0;
      end else if (last_col) begin
        col_count  <= '0;
        page_count <= page_count + PTW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Job control
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_step  <= ST_H0;
      tail_col  <= '0;
    end else begin
      if (out_load) begin
        case (job_step)
          ST_DB:   job_step <= ST_T0;
          ST_T0:   job_step <= ST_T1;
          ST_T1:   job_step <= ST_T2;
          ST_T2: begin
            job_step <= ST_TB;
            tail_col <= '0;
          end
          ST_TB:   tail_col <= tail_col + CW'(1);
          ST_H0:   job_step <= ST_H1;
          ST_H1:   job_step <= ST_H2;
          ST_H2:   job_step <= ST_DB;
          default: job_step <= ST_H0;
        endcase
        if (step_final) begin
          job_valid <= 1'b0;
        end
      end
      if (pix_take) begin
        job_valid <= 1'b1;
        job_step  <= (col_count == '0) ? ST_H0 : ST_DB;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (pix_take) begin
      job_page  <= 8'(first_page) + 8'(page_count);
      job_byte  <= shifted[7:0];
      job_spill <= shifted[15:8];
      job_col   <= col_count;
      job_merge <= (page_count != '0);
      job_tail  <= last_col && last_page && (row_shift != 3'd0);
      job_fin   <= last_col && last_page;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload and spill row store: read of old spill and write of new in the same cycle
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_done <= step_final && job_fin;
      m_tlast  <= step_final;
      case (job_step)
        ST_H0, ST_T0: begin
          m_tdata     <= opbb_pkg::PAGE_CMD_BASE + hdr_page;
          out_is_data <= 1'b0;
        end
        ST_H1, ST_T1: begin
          m_tdata     <= opbb_pkg::COL_LO_CMD_BASE + (origin_col & opbb_pkg::NIBBLE_MASK);
          out_is_data <= 1'b0;
        end
        ST_H2, ST_T2: begin
          m_tdata     <= opbb_pkg::COL_HI_CMD_BASE + (origin_col >> 4);
          out_is_data <= 1'b0;
        end
        ST_DB: begin
          m_tdata     <= job_byte | (job_merge ? prev_page_row[rd_addr] : 8'h00);
          out_is_data <= 1'b1;
          prev_page_row[rd_addr] <= job_spill;
        end
        default: begin
          m_tdata     <= prev_page_row[rd_addr];
          out_is_data <= 1'b1;
        end
      endcase
    end
  end

  assign m_tuser = {out_done, out_is_data};

endmodule

`default_nettype wire
